FILE: hdl/spq_pkg.sv
// Shared types and constants for the strict priority task queue.
// No dependencies; every other file of the block uses this package.
package spq_pkg;

	typedef enum logic {
		CMD_POST = 1'b0,
		CMD_TAKE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPRI = 2'd3
	} status_t;

	// Reset value of the levels-in-use register.
	localparam logic [3:0] LEVELS_RESET = 4'd8;

	// Strobes from the level control to the handle store.
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_ctl_t;

	// Everything of one result except the handle, which comes from the store.
	typedef struct packed {
		logic       dispatched;
		logic [2:0] out_priority;
		status_t    status;
		logic [7:0] pending_total;
	} result_t;

endpackage

FILE: hdl/spq_if.sv
// Valid/ready channel interfaces for the command and result transactions.
// Depends on spq_pkg for the command and status types.
interface spq_cmd_if;
	logic              valid;
	logic              ready;
	spq_pkg::cmd_t     command;
	logic [15:0]       task_handle;
	logic [2:0]        priority_req;

	modport source(output valid, output command, output task_handle, output priority_req,
		input ready);
	modport sink(input valid, input command, input task_handle, input priority_req,
		output ready);
endinterface

interface spq_res_if;
	logic              valid;
	logic              ready;
	logic              dispatched;
	logic [15:0]       out_handle;
	logic [2:0]        out_priority;
	spq_pkg::status_t  status;
	logic [7:0]        pending_total;

	modport source(output valid, output dispatched, output out_handle, output out_priority,
		output status, output pending_total, input ready);
	modport sink(input valid, input dispatched, input out_handle, input out_priority,
		input status, input pending_total, output ready);
endinterface

FILE: hdl/spq_store.sv
// Handle memory: one region of slots per priority level, addressed {level, slot}.
// Depends on spq_pkg for the access strobes; read data is registered.
module spq_store #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                                             clk,
	input  spq_pkg::mem_ctl_t                                mem_ctl,
	input  logic [$clog2(NUM_LEVELS)+$clog2(QUEUE_DEPTH)-1:0] addr,
	input  logic [HANDLE_BITS-1:0]                           wdata,
	output logic [HANDLE_BITS-1:0]                           rdata
);
	import spq_pkg::*;

	localparam int AW    = $clog2(NUM_LEVELS) + $clog2(QUEUE_DEPTH);
	localparam int DEPTH = 2 ** AW;

	logic [HANDLE_BITS-1:0] mem_q [DEPTH];
	logic [HANDLE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_ctl.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/spq_ctrl.sv
// Per-level FIFO pointers and counts, the highest-level search and the pending total.
// Depends on spq_pkg; drives the handle store and produces the result fields.
module spq_ctrl #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_we,
	input  logic [3:0]                                       cfg_data,
	input  logic                                             go,
	input  spq_pkg::cmd_t                                    command,
	input  logic [2:0]                                       priority_req,
	output spq_pkg::mem_ctl_t                                mem_ctl,
	output logic [$clog2(NUM_LEVELS)+$clog2(QUEUE_DEPTH)-1:0] mem_addr,
	output spq_pkg::result_t                                 result
);
	import spq_pkg::*;

	localparam int LVW = $clog2(NUM_LEVELS);
	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int PW  = $clog2(NUM_LEVELS * QUEUE_DEPTH + 1);

	logic [QW-1:0]  head_q  [NUM_LEVELS];
	logic [QW-1:0]  tail_q  [NUM_LEVELS];
	logic [CW-1:0]  count_q [NUM_LEVELS];
	logic [PW-1:0]  pending_q;
	logic [3:0]     levels_q;

	logic [LVW-1:0] post_lvl;
	logic [LVW-1:0] take_lvl;
	logic           found;
	logic           bad_pri;
	logic           full;
	logic           post_ok;
	logic           take_ok;
	logic [PW-1:0]  pending_nxt;
	status_t        status;

	// Highest non-empty level; the search covers every level regardless of the register.
	always_comb begin
		found    = 1'b0;
		take_lvl = '0;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (count_q[l] != '0) begin
				found    = 1'b1;
				take_lvl = LVW'(l);
			end
		end
	end

	// A register value of zero acts as one level; values above the level count saturate.
	always_comb begin
		if (levels_q == '0) begin
			bad_pri = (priority_req != '0);
		end else begin
			bad_pri = ({1'b0, priority_req} >= levels_q) ||
				(int'(priority_req) >= NUM_LEVELS);
		end
	end

	assign post_lvl = LVW'(priority_req);
	assign full     = !bad_pri && (count_q[post_lvl] == CW'(QUEUE_DEPTH));
	assign post_ok  = (command == CMD_POST) && !bad_pri && !full;
	assign take_ok  = (command == CMD_TAKE) && found;

	always_comb begin
		if (command == CMD_POST) begin
			if (bad_pri) begin
				status = ST_BADPRI;
			end else if (full) begin
				status = ST_FULL;
			end else begin
				status = ST_OK;
			end
		end else begin
			status = found ? ST_OK : ST_EMPTY;
		end
	end

	assign pending_nxt = pending_q + PW'(post_ok) - PW'(take_ok);

	always_comb begin
		mem_ctl.wr = go && post_ok;
		mem_ctl.rd = go && take_ok;
		if (command == CMD_POST) begin
			mem_addr = {post_lvl, tail_q[post_lvl]};
		end else begin
			mem_addr = {take_lvl, head_q[take_lvl]};
		end
	end

	always_comb begin
		result.dispatched    = take_ok;
		result.out_priority  = take_ok ? 3'(take_lvl) : 3'd0;
		result.status        = status;
		result.pending_total = 8'(pending_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= LEVELS_RESET;
		end else if (cfg_we) begin
			levels_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
			pending_q <= '0;
		end else if (go) begin
			if (post_ok) begin
				tail_q[post_lvl]  <= (tail_q[post_lvl] == QW'(QUEUE_DEPTH - 1)) ? '0 :
					tail_q[post_lvl] + 1'b1;
				count_q[post_lvl] <= count_q[post_lvl] + 1'b1;
			end
			if (take_ok) begin
				head_q[take_lvl]  <= (head_q[take_lvl] == QW'(QUEUE_DEPTH - 1)) ? '0 :
					head_q[take_lvl] + 1'b1;
				count_q[take_lvl] <= count_q[take_lvl] - 1'b1;
			end
			pending_q <= pending_nxt;
		end
	end

endmodule

FILE: hdl/strict_priority_task_queue.sv
// Strict priority task queue, top level.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_store.
//
// The cmd_ch channel carries post and take commands; each transaction on it
// yields exactly one transaction on res_ch, in order. A post appends its
// handle to the FIFO of its priority level; a take returns the oldest handle
// of the highest non-empty level. Write the levels-in-use register
// (cfg_we/cfg_data) only while no command is in flight; it is not enforced.
//
// A command is captured in an input register, decided against the level
// pointers and counts when it moves on, and lands in the result register
// together with the handle read from the store. One command is accepted
// every cycle as long as res_ch keeps taking results.
//
// When res_ch stalls, the result register holds, the input register fills,
// and cmd_ch.ready drops until the stall clears. Reset empties every level,
// clears the pending total and sets levels in use to eight; the handle
// memory itself is not cleared, and the block is ready right after reset.
module strict_priority_task_queue #(
	parameter int NUM_LEVELS  = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	spq_cmd_if.sink     cmd_ch,
	spq_res_if.source   res_ch
);
	import spq_pkg::*;

	localparam int AW = $clog2(NUM_LEVELS) + $clog2(QUEUE_DEPTH);

	logic                   valid_s1;
	cmd_t                   command_s1;
	logic [15:0]            handle_s1;
	logic [2:0]             priority_s1;
	logic                   valid_s2;
	result_t                res_s2;

	logic                   s2_load;
	logic                   s1_adv;
	mem_ctl_t               mem_ctl;
	logic [AW-1:0]          mem_addr;
	logic [HANDLE_BITS-1:0] rdata;
	result_t                result;

	assign s2_load      = !valid_s2 || res_ch.ready;
	assign s1_adv       = valid_s1 && s2_load;
	assign cmd_ch.ready = !valid_s1 || s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd_ch.ready) begin
				valid_s1 <= cmd_ch.valid;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			command_s1  <= cmd_ch.command;
			handle_s1   <= cmd_ch.task_handle;
			priority_s1 <= cmd_ch.priority_req;
		end
		if (s1_adv) begin
			res_s2 <= result;
		end
	end

	spq_ctrl #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.go           (s1_adv),
		.command      (command_s1),
		.priority_req (priority_s1),
		.mem_ctl      (mem_ctl),
		.mem_addr     (mem_addr),
		.result       (result)
	);

	spq_store #(
		.NUM_LEVELS  (NUM_LEVELS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_store (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.addr    (mem_addr),
		.wdata   (HANDLE_BITS'(handle_s1)),
		.rdata   (rdata)
	);

	// The store's read register only loads on a dispatching take, so gate it here.
	assign res_ch.valid         = valid_s2;
	assign res_ch.dispatched    = res_s2.dispatched;
	assign res_ch.out_handle    = res_s2.dispatched ? 16'(rdata) : 16'd0;
	assign res_ch.out_priority  = res_s2.out_priority;
	assign res_ch.status        = res_s2.status;
	assign res_ch.pending_total = res_s2.pending_total;

endmodule

FILE: dv/strict_priority_task_queue_test.sv
// Self-checking test of strict_priority_task_queue: posts and takes with random gaps on both
// channels, every result predicted and compared. Depends on spq_pkg, spq_if and the RTL.
module strict_priority_task_queue_test;
	import spq_pkg::*;

	localparam int NUM_LEVELS  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic        dispatched;
		logic [15:0] handle;
		logic [2:0]  level;
		status_t     status;
		logic [7:0]  pending;
	} task_result_t;

	class task_queue_scoreboard;
		logic [15:0]  slots [NUM_LEVELS][QUEUE_DEPTH];
		int           head [NUM_LEVELS];
		int           tail [NUM_LEVELS];
		int           fill_count [NUM_LEVELS];
		int           pending;
		logic [3:0]   levels_reg;
		task_result_t awaited_results [$];
		int           errors;

		function new();
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head[i] = 0;
				tail[i] = 0;
				fill_count[i] = 0;
			end
			pending = 0;
			levels_reg = LEVELS_RESET;
			errors = 0;
		endfunction

		function void write_levels(logic [3:0] value);
			levels_reg = value;
		endfunction

		// Zero behaves as one level, anything above the level count as all of them.
		function int active_levels();
			if (levels_reg == 4'd0)
				return 1;
			if (levels_reg > NUM_LEVELS)
				return NUM_LEVELS;
			return levels_reg;
		endfunction

		function void note_command(cmd_t cmd, logic [15:0] handle, logic [2:0] level);
			task_result_t r;
			int           lvl;
			r = '{1'b0, 16'h0000, 3'd0, ST_OK, 8'd0};
			if (cmd == CMD_POST) begin
				if (level >= active_levels()) begin
					r.status = ST_BADPRI;
				end else if (fill_count[level] >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slots[level][tail[level]] = handle;
					tail[level] = (tail[level] + 1) % QUEUE_DEPTH;
					fill_count[level]++;
					pending++;
				end
			end else begin
				// A take scans every level, whatever the register says now.
				lvl = -1;
				for (int i = NUM_LEVELS - 1; i >= 0; i--)
					if (lvl < 0 && fill_count[i] > 0)
						lvl = i;
				if (lvl < 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.dispatched = 1'b1;
					r.handle = slots[lvl][head[lvl]];
					r.level = lvl[2:0];
					head[lvl] = (head[lvl] + 1) % QUEUE_DEPTH;
					fill_count[lvl]--;
					pending--;
				end
			end
			r.pending = pending[7:0];
			awaited_results.push_back(r);
		endfunction

		function void report(string what, logic [15:0] want, logic [15:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
		endfunction

		function void check_result(logic dispatched, logic [15:0] handle, logic [2:0] level,
			status_t status, logic [7:0] pend);
			task_result_t r;
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: result transaction with none expected, actual handle %0h",
					$time, handle);
				return;
			end
			r = awaited_results.pop_front();
			if (dispatched !== r.dispatched)
				report("dispatched", r.dispatched, dispatched);
			if (handle !== r.handle)
				report("out_handle", r.handle, handle);
			if (level !== r.level)
				report("out_priority", r.level, level);
			if (status !== r.status)
				report("status", r.status, status);
			if (pend !== r.pending)
				report("pending_total", r.pending, pend);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_data;
	int         src_idle_pct;
	int         sink_idle_pct;

	task_queue_scoreboard sb;

	spq_cmd_if cmd_ch();
	spq_res_if res_ch();

	strict_priority_task_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.cmd_ch(cmd_ch),
		.res_ch(res_ch)
	);

	always #2 clk = ~clk;

	// Results are taken with random back-pressure; values read here are those before the edge.
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result(res_ch.dispatched, res_ch.out_handle, res_ch.out_priority,
				res_ch.status, res_ch.pending_total);
		res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("strict_priority_task_queue_test failed");
		$finish;
	end

	task send_command(input cmd_t cmd, input logic [15:0] handle, input logic [2:0] level);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= cmd;
		cmd_ch.task_handle <= handle;
		cmd_ch.priority_req <= level;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		sb.note_command(cmd, handle, level);
	endtask

	// The register may only change once every command in flight has produced its result.
	task quiesce_and_set_levels(input logic [3:0] value);
		cmd_ch.valid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_levels(value);
	endtask

	// Blocks of twenty transactions lean toward filling, draining or a mix, so levels run full
	// and empty often.
	task run_random_chunk(input int count);
		int          leaning;
		int          post_pct;
		int          focus;
		int          pick;
		logic [2:0]  level;
		logic [15:0] handle;
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0) begin
				leaning = $urandom_range(2);
				post_pct = (leaning == 0) ? 85 : (leaning == 1) ? 20 : 55;
				focus = $urandom_range(sb.active_levels() - 1);
			end
			pick = $urandom_range(19);
			handle = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hffff : 16'($urandom);
			pick = $urandom_range(99);
			if (pick < 15)
				level = 3'($urandom_range(7));
			else if (leaning == 0 && pick < 70)
				level = 3'(focus);
			else
				level = 3'($urandom_range(sb.active_levels() - 1));
			if ($urandom_range(99) < post_pct)
				send_command(CMD_POST, handle, level);
			else
				send_command(CMD_TAKE, 16'($urandom), 3'($urandom_range(7)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 4'd0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_POST;
		cmd_ch.task_handle = 16'h0000;
		cmd_ch.priority_req = 3'd0;
		res_ch.ready = 1'b0;
		src_idle_pct = 31;
		sink_idle_pct = 52;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset register value: empty take, then posts served highest level first.
		send_command(CMD_TAKE, 16'h1234, 3'd5);
		send_command(CMD_POST, 16'hffff, 3'd7);
		send_command(CMD_POST, 16'h0000, 3'd0);
		send_command(CMD_POST, 16'h5a5a, 3'd3);
		send_command(CMD_POST, 16'ha5a5, 3'd3);
		send_command(CMD_TAKE, 16'h0000, 3'd0);
		send_command(CMD_TAKE, 16'hffff, 3'd7);
		send_command(CMD_TAKE, 16'h0000, 3'd0);
		send_command(CMD_POST, 16'h0001, 3'd7);
		send_command(CMD_TAKE, 16'h0000, 3'd0);
		send_command(CMD_TAKE, 16'h0000, 3'd0);

		// Priorities beyond the register are refused.
		quiesce_and_set_levels(4'd2);
		send_command(CMD_POST, 16'h0bad, 3'd2);
		send_command(CMD_POST, 16'h0bad, 3'd7);
		send_command(CMD_POST, 16'h0002, 3'd1);
		quiesce_and_set_levels(4'd0);
		send_command(CMD_POST, 16'h0bad, 3'd1);
		send_command(CMD_POST, 16'h0003, 3'd0);
		quiesce_and_set_levels(4'd15);
		send_command(CMD_POST, 16'h0004, 3'd7);

		// After lowering the register, tasks already posted on high levels still come out.
		quiesce_and_set_levels(4'd1);
		send_command(CMD_TAKE, 16'h0000, 3'd0);
		send_command(CMD_TAKE, 16'h0000, 3'd0);
		send_command(CMD_TAKE, 16'h0000, 3'd0);
		send_command(CMD_TAKE, 16'h0000, 3'd0);

		quiesce_and_set_levels(4'd8);
		run_random_chunk(140);
		quiesce_and_set_levels(4'd1);
		run_random_chunk(140);

		src_idle_pct = 52;
		sink_idle_pct = 31;
		quiesce_and_set_levels(4'd15);
		run_random_chunk(140);
		quiesce_and_set_levels(4'd0);
		run_random_chunk(140);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		quiesce_and_set_levels(4'($urandom_range(1, 8)));
		run_random_chunk(140);
		quiesce_and_set_levels(4'd9);
		run_random_chunk(140);

		cmd_ch.valid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("strict_priority_task_queue_test passed");
		else
			$display("strict_priority_task_queue_test failed");
		$finish;
	end
endmodule

FILE: sim.f
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_store.sv
hdl/spq_ctrl.sv
hdl/strict_priority_task_queue.sv
dv/strict_priority_task_queue_test.sv
